// ===== sv/spem_pkg.sv =====
// Shared types and constants for the SNR and peak error meter.
// Used by the interfaces, the controller, the datapath and the checker.
// No dependencies.
package spem_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int ACC_W      = 64;
	localparam int SQ_W       = 32;
	localparam int POS_W      = 6;
	localparam int SNR_W      = 17;
	localparam int STATUS_W   = 2;
	localparam int NORM_STEPS = 6;

	// 10*log10(2) scaled by 2^16
	localparam logic [17:0] SNR_SCALE = 18'd197283;

	typedef enum logic [STATUS_W-1:0] {
		ST_VALID    = 2'd0,
		ST_ERR_ZERO = 2'd1,
		ST_SIG_ZERO = 2'd2
	} snr_status_t;

	typedef enum logic [2:0] {
		S_ACC,
		S_CHECK,
		S_NORM_A,
		S_SQ_A,
		S_NORM_B,
		S_SQ_B,
		S_MUL,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic       in_ready;
		logic       load_x;
		logic       load_sel_err;
		logic       norm_en;
		logic [2:0] norm_step;
		logic       sq_init;
		logic       sq_round;
		logic       save_a;
		logic       mul_en;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic last_pending;
		logic zero_sig;
		logic zero_err;
		logic out_free;
	} sts_t;

endpackage

// ===== sv/spem_if.sv =====
// Valid/ready channel interfaces for sample pair words and result words.
// Depends on spem_pkg for field widths.
interface spem_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [spem_pkg::SAMPLE_W-1:0] original_sample;
	logic signed [spem_pkg::SAMPLE_W-1:0] modified_sample;
	logic                                last_pair;

	modport source (output valid, original_sample, modified_sample, last_pair, input ready);
	modport sink (input valid, original_sample, modified_sample, last_pair, output ready);
endinterface

interface spem_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [spem_pkg::SNR_W-1:0]    snr_db_q8;
	logic [spem_pkg::SAMPLE_W-1:0]        max_abs_error;
	logic [spem_pkg::STATUS_W-1:0]        snr_status;

	modport source (output valid, snr_db_q8, max_abs_error, snr_status, input ready);
	modport sink (input valid, snr_db_q8, max_abs_error, snr_status, output ready);
endinterface

// ===== sv/spem_ctrl.sv =====
// Controller state machine for the SNR and peak error meter.
// Depends on spem_pkg; drives the datapath through cmd_t and reads sts_t.
module spem_ctrl #(
	parameter int LFB = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  spem_pkg::sts_t  sts,
	output spem_pkg::cmd_t  cmd
);

	localparam int CNT_W = $clog2(LFB + 1);
	localparam logic [CNT_W-1:0] LAST_NORM = CNT_W'(spem_pkg::NORM_STEPS - 1);
	localparam logic [CNT_W-1:0] LAST_SQ   = CNT_W'(LFB);

	spem_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spem_pkg::S_ACC;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.norm_step = cnt_q[2:0];
		state_d       = state_q;
		cnt_d         = cnt_q;
		unique case (state_q)
			spem_pkg::S_ACC: begin
				cmd.in_ready = !sts.last_pending;
				if (sts.last_pending) begin
					state_d = spem_pkg::S_CHECK;
				end
			end
			spem_pkg::S_CHECK: begin
				if (sts.zero_sig || sts.zero_err) begin
					state_d = spem_pkg::S_EMIT;
				end else begin
					cmd.load_x = 1'b1;
					cnt_d      = '0;
					state_d    = spem_pkg::S_NORM_A;
				end
			end
			spem_pkg::S_NORM_A, spem_pkg::S_NORM_B: begin
				cmd.norm_en = 1'b1;
				if (cnt_q == LAST_NORM) begin
					cnt_d   = '0;
					state_d = (state_q == spem_pkg::S_NORM_A) ? spem_pkg::S_SQ_A
					                                          : spem_pkg::S_SQ_B;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			spem_pkg::S_SQ_A, spem_pkg::S_SQ_B: begin
				// The first cycle squares the normalized mantissa; each later
				// cycle resolves one fraction bit and squares again.
				cmd.sq_init  = (cnt_q == '0);
				cmd.sq_round = (cnt_q != '0);
				if (cnt_q == LAST_SQ) begin
					cnt_d = '0;
					if (state_q == spem_pkg::S_SQ_A) begin
						cmd.save_a       = 1'b1;
						cmd.load_x       = 1'b1;
						cmd.load_sel_err = 1'b1;
						state_d          = spem_pkg::S_NORM_B;
					end else begin
						state_d = spem_pkg::S_MUL;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			spem_pkg::S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = spem_pkg::S_EMIT;
			end
			spem_pkg::S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = spem_pkg::S_ACC;
				end
			end
			default: begin
				state_d = spem_pkg::S_ACC;
			end
		endcase
	end

endmodule

// ===== sv/spem_dp.sv =====
// Datapath for the SNR and peak error meter: squares, saturating energy
// accumulators, peak tracker, shared log2 unit, dB scaling and output word.
// Depends on spem_pkg and the channel interfaces in spem_if.
module spem_dp #(
	parameter int LFB = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  spem_pkg::cmd_t  cmd,
	output spem_pkg::sts_t  sts,
	spem_in_if.sink         in_ch,
	spem_out_if.source      out_ch
);

	localparam int SW     = spem_pkg::SAMPLE_W;
	localparam int AW     = spem_pkg::ACC_W;
	localparam int QW     = spem_pkg::SQ_W;
	localparam int LOG_W  = spem_pkg::POS_W + LFB;
	localparam int DIFF_W = LOG_W + 1;
	localparam int MUL_W  = DIFF_W + 19;
	localparam int SHIFT  = 8 + LFB;

	logic                  accept;
	logic signed [SW:0]    diff_in;
	logic [SW:0]           dmag_in;
	logic [SW-1:0]         omag_in;

	logic                  valid_s1;
	logic                  last_s1;
	logic [QW-1:0]         sq_sig_s1;
	logic [QW-1:0]         sq_err_s1;
	logic [SW-1:0]         dmag_s1;

	logic [AW-1:0]         sig_acc_q;
	logic [AW-1:0]         err_acc_q;
	logic [SW-1:0]         peak_q;
	logic [AW:0]           sig_sum;
	logic [AW:0]           err_sum;

	logic [AW-1:0]         x_q, x_n;
	logic [spem_pkg::POS_W-1:0] p_q, p_n;
	logic [2*QW-1:0]       prod_q;
	logic [2*QW-1:0]       sq_d;
	logic [QW:0]           t;
	logic                  fbit;
	logic [QW-1:0]         m_new;
	logic [QW-1:0]         m_sel;
	logic [LFB-1:0]        frac_q;
	logic [LFB-1:0]        frac_n;
	logic [LOG_W-1:0]      la_q;
	logic [LOG_W-1:0]      lb;
	logic signed [DIFF_W-1:0] diff_d;
	logic signed [MUL_W-1:0]  mul_d;
	logic signed [MUL_W-1:0]  mul_q;

	spem_pkg::snr_status_t status_d;
	logic                  out_valid_q;
	logic signed [spem_pkg::SNR_W-1:0] snr_q;
	logic [SW-1:0]         peak_out_q;
	logic [spem_pkg::STATUS_W-1:0] status_q;

	// Input stage: magnitudes and exact squares.
	assign in_ch.ready = cmd.in_ready;
	assign accept      = in_ch.valid & cmd.in_ready;
	assign diff_in     = {in_ch.original_sample[SW-1], in_ch.original_sample}
	                   - {in_ch.modified_sample[SW-1], in_ch.modified_sample};
	assign dmag_in     = diff_in[SW] ? (SW+1)'(-diff_in) : diff_in;
	assign omag_in     = in_ch.original_sample[SW-1] ? SW'(-in_ch.original_sample)
	                                                 : in_ch.original_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1   <= in_ch.last_pair;
			sq_sig_s1 <= omag_in * omag_in;
			sq_err_s1 <= dmag_in[SW-1:0] * dmag_in[SW-1:0];
			dmag_s1   <= dmag_in[SW-1:0];
		end
	end

	// Saturating accumulators and peak tracker.
	assign sig_sum = {1'b0, sig_acc_q} + {{(AW+1-QW){1'b0}}, sq_sig_s1};
	assign err_sum = {1'b0, err_acc_q} + {{(AW+1-QW){1'b0}}, sq_err_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_acc_q <= '0;
			err_acc_q <= '0;
			peak_q    <= '0;
		end else if (cmd.emit) begin
			sig_acc_q <= '0;
			err_acc_q <= '0;
			peak_q    <= '0;
		end else if (valid_s1) begin
			sig_acc_q <= sig_sum[AW] ? '1 : sig_sum[AW-1:0];
			err_acc_q <= err_sum[AW] ? '1 : err_sum[AW-1:0];
			if (dmag_s1 > peak_q) begin
				peak_q <= dmag_s1;
			end
		end
	end

	// Leading-one search: one binary step per cycle, widest first.
	always_comb begin
		x_n = x_q;
		p_n = p_q;
		case (cmd.norm_step)
			3'd0: if (x_q[63:32] == '0) begin
				x_n = {x_q[31:0], 32'b0};
				p_n = p_q - 6'd32;
			end
			3'd1: if (x_q[63:48] == '0) begin
				x_n = {x_q[47:0], 16'b0};
				p_n = p_q - 6'd16;
			end
			3'd2: if (x_q[63:56] == '0) begin
				x_n = {x_q[55:0], 8'b0};
				p_n = p_q - 6'd8;
			end
			3'd3: if (x_q[63:60] == '0) begin
				x_n = {x_q[59:0], 4'b0};
				p_n = p_q - 6'd4;
			end
			3'd4: if (x_q[63:62] == '0) begin
				x_n = {x_q[61:0], 2'b0};
				p_n = p_q - 6'd2;
			end
			3'd5: if (!x_q[63]) begin
				x_n = {x_q[62:0], 1'b0};
				p_n = p_q - 6'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= cmd.load_sel_err ? err_acc_q : sig_acc_q;
			p_q <= '1;
		end else if (cmd.norm_en) begin
			x_q <= x_n;
			p_q <= p_n;
		end
	end

	// Fraction by repeated squaring of the Q1.31 mantissa.
	assign t      = prod_q[2*QW-1:QW-1];
	assign fbit   = t[QW];
	assign m_new  = fbit ? t[QW:1] : t[QW-1:0];
	assign m_sel  = cmd.sq_init ? x_q[AW-1:AW-QW] : m_new;
	assign sq_d   = m_sel * m_sel;
	assign frac_n = {frac_q[LFB-2:0], fbit};

	always_ff @(posedge clk) begin
		if (cmd.sq_init || cmd.sq_round) begin
			prod_q <= sq_d;
		end
		if (cmd.sq_round) begin
			frac_q <= frac_n;
		end
		if (cmd.save_a) begin
			la_q <= {p_q, frac_n};
		end
		if (cmd.mul_en) begin
			mul_q <= mul_d;
		end
	end

	// The part-select of the signed product is the floor of the scaled ratio.
	assign lb     = {p_q, frac_q};
	assign diff_d = $signed({1'b0, la_q}) - $signed({1'b0, lb});
	assign mul_d  = diff_d * $signed({1'b0, spem_pkg::SNR_SCALE});

	always_comb begin
		if (sig_acc_q == '0) begin
			status_d = spem_pkg::ST_SIG_ZERO;
		end else if (err_acc_q == '0) begin
			status_d = spem_pkg::ST_ERR_ZERO;
		end else begin
			status_d = spem_pkg::ST_VALID;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			snr_q      <= (status_d == spem_pkg::ST_VALID) ? mul_q[SHIFT+16:SHIFT] : '0;
			peak_out_q <= peak_q;
			status_q   <= status_d;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.snr_db_q8     = snr_q;
	assign out_ch.max_abs_error = peak_out_q;
	assign out_ch.snr_status    = status_q;

	assign sts.last_pending = valid_s1 & last_s1;
	assign sts.zero_sig     = (sig_acc_q == '0);
	assign sts.zero_err     = (err_acc_q == '0);
	assign sts.out_free     = !out_valid_q || out_ch.ready;

endmodule

// ===== sv/snr_and_peak_error_meter.sv =====
// Throughput: one sample pair word per cycle while a measurement runs.
// After the last pair, the time to a valid result word is set by the shared log2
// unit: six leading-one steps and one squaring per fraction bit for each energy;
// the log2 unit is skipped when either energy is zero. Input is held off from the
// cycle after the last pair until the result loads. Reset clears the energies,
// the peak and any pending result.
module snr_and_peak_error_meter #(
	parameter int LOG_FRACTION_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	spem_in_if.sink    in_ch,
	spem_out_if.source out_ch
);

	spem_pkg::cmd_t cmd;
	spem_pkg::sts_t sts;

	spem_ctrl #(
		.LFB (LOG_FRACTION_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	spem_dp #(
		.LFB (LOG_FRACTION_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

// ===== sv/spem_checker.sv =====
// Port-level checks for the SNR and peak error meter, bound to the top level.
// Depends on spem_pkg and the channel interfaces in spem_if.
module spem_checker (
	input logic        clk,
	input logic        arst_n,
	spem_in_if.sink    in_ch,
	spem_out_if.source out_ch
);

	// A measurement closes on its last pair; the next word waits for the result.
	a_hold_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.last_pair |=> !in_ch.ready)
		else $error("input accepted right after a last pair");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.snr_db_q8)
		&& $stable(out_ch.max_abs_error) && $stable(out_ch.snr_status))
		else $error("stalled result word changed");

	a_snr_zero_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.snr_status != spem_pkg::ST_VALID |-> out_ch.snr_db_q8 == '0)
		else $error("nonzero SNR with a nonzero status");

	// Zero error energy means every difference was zero.
	a_peak_zero_on_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.snr_status == spem_pkg::ST_ERR_ZERO
		|-> out_ch.max_abs_error == '0)
		else $error("peak error nonzero while error energy is zero");

endmodule

bind snr_and_peak_error_meter spem_checker u_spem_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.in_ch  (in_ch),
	.out_ch (out_ch)
);

// ===== verif/tb_snr_and_peak_error_meter.sv =====
// Self-checking testbench for the SNR and peak error meter.
// Drives sample pair words through spem_in_if and checks result words from spem_out_if.
// Depends on spem_pkg, the channel interfaces and the snr_and_peak_error_meter RTL.
`timescale 1ns / 100ps

typedef struct {
	logic signed [spem_pkg::SNR_W-1:0] snr;
	logic [spem_pkg::SAMPLE_W-1:0]     peak;
	spem_pkg::snr_status_t             status;
} meter_result_t;

typedef enum int unsigned {
	K_RANDOM,
	K_NOISY,
	K_EXACT,
	K_MUTE,
	K_QUIET,
	K_EXTREME
} pair_kind_t;

class snr_meter_scoreboard;
	localparam int LOG_FRAC = 16;

	bit [63:0]     sig_energy = '0;
	bit [63:0]     err_energy = '0;
	bit [15:0]     peak = '0;
	meter_result_t expected_q[$];
	int unsigned   errors = 0;
	int unsigned   pairs = 0;
	int unsigned   measurements = 0;
	int unsigned   checked = 0;
	int unsigned   status_count[3] = '{0, 0, 0};
	int unsigned   negative_snr = 0;

	function automatic bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
		bit [63:0] sum;
		sum = a + b;
		if (sum < a)
			sum = '1;
		return sum;
	endfunction

	// Leading-one position as the integer part, then one truncated squaring per fraction bit.
	function automatic bit [63:0] log2_fix(bit [63:0] x);
		int        pos;
		bit [63:0] mant;
		bit [63:0] frac;
		pos = 0;
		frac = '0;
		for (int i = 0; i < 64; i++)
			if (x[i])
				pos = i;
		if (pos >= 31)
			mant = x >> (pos - 31);
		else
			mant = x << (31 - pos);
		for (int i = 0; i < LOG_FRAC; i++) begin
			mant = (mant * mant) >> 31;
			frac = frac << 1;
			if (mant >= 64'h1_0000_0000) begin
				frac[0] = 1'b1;
				mant = mant >> 1;
			end
		end
		return (64'(pos) << LOG_FRAC) | frac;
	endfunction

	function void note_pair(logic signed [15:0] orig, logic signed [15:0] mod, bit last);
		int            os;
		int            ms;
		int            diff;
		bit [63:0]     ad;
		bit [63:0]     ao;
		bit [63:0]     la;
		bit [63:0]     lb;
		bit [63:0]     q;
		bit [63:0]     scale;
		bit [63:0]     snr_bits;
		meter_result_t res;
		os = orig;
		ms = mod;
		diff = os - ms;
		ad = (diff < 0) ? 64'(-diff) : 64'(diff);
		ao = (os < 0) ? 64'(-os) : 64'(os);
		pairs++;
		sig_energy = sat_add(sig_energy, ao * ao);
		err_energy = sat_add(err_energy, ad * ad);
		if (ad > 64'(peak))
			peak = ad[15:0];
		if (!last)
			return;
		snr_bits = '0;
		scale = 64'(spem_pkg::SNR_SCALE);
		if (sig_energy == 0) begin
			res.status = spem_pkg::ST_SIG_ZERO;
		end else if (err_energy == 0) begin
			res.status = spem_pkg::ST_ERR_ZERO;
		end else begin
			res.status = spem_pkg::ST_VALID;
			la = log2_fix(sig_energy);
			lb = log2_fix(err_energy);
			if (la >= lb) begin
				snr_bits = ((la - lb) * scale) >> (8 + LOG_FRAC);
			end else begin
				// Rounds toward minus infinity for a negative ratio.
				q = ((lb - la) * scale + ((64'd1 << (8 + LOG_FRAC)) - 1)) >> (8 + LOG_FRAC);
				snr_bits = 64'd0 - q;
				negative_snr++;
			end
		end
		res.snr = snr_bits[16:0];
		res.peak = peak;
		expected_q = {expected_q, res};
		measurements++;
		status_count[int'(res.status)]++;
		sig_energy = '0;
		err_energy = '0;
		peak = '0;
	endfunction

	function void check_result(logic signed [16:0] snr, logic [15:0] pk, logic [1:0] st);
		meter_result_t exp_res;
		if (expected_q.size() == 0) begin
			$display("%0t: result word with nothing expected: snr %0d peak %0d status %0d",
				$time, snr, pk, st);
			errors++;
			return;
		end
		exp_res = expected_q.pop_front();
		checked++;
		if (snr !== exp_res.snr) begin
			$display("%0t: snr_db_q8 expected %0d, got %0d", $time, exp_res.snr, snr);
			errors++;
		end
		if (pk !== exp_res.peak) begin
			$display("%0t: max_abs_error expected %0d, got %0d", $time, exp_res.peak, pk);
			errors++;
		end
		if (st !== exp_res.status) begin
			$display("%0t: snr_status expected %0d, got %0d", $time, exp_res.status, st);
			errors++;
		end
	endfunction

	function int unsigned outstanding();
		return expected_q.size();
	endfunction
endclass

module tb_snr_and_peak_error_meter;
	localparam int LOG_FRAC    = 16;
	localparam int ITEMS       = 1800;
	localparam int LATENCY     = 2 * LOG_FRAC + 18;
	localparam int CYCLE_LIMIT = 600000;

	logic clk;
	logic arst_n;

	spem_in_if  in_ch();
	spem_out_if out_ch();

	snr_meter_scoreboard sb;
	bit          idle_on = 1'b1;
	int unsigned hold_req = 0;
	int unsigned sent_pairs = 0;
	int unsigned cycles = 0;

	snr_and_peak_error_meter #(
		.LOG_FRACTION_BITS(LOG_FRAC)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding",
			cycles, sb.outstanding());
		$display("** snr_and_peak_error_meter: FAILED **");
		$finish;
	end

	// Offers one pair word, with random idle cycles before it, and waits for acceptance.
	task automatic send_pair(input int o, input int m, input bit last);
		while (idle_on && $urandom_range(99) < 21) begin
			in_ch.valid <= 1'b0;
			in_ch.original_sample <= 16'($urandom);
			in_ch.modified_sample <= 16'($urandom);
			in_ch.last_pair <= 1'($urandom);
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.original_sample <= o[15:0];
		in_ch.modified_sample <= m[15:0];
		in_ch.last_pair <= last;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		sb.note_pair(o[15:0], m[15:0], last);
		sent_pairs++;
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_extreme();
		case ($urandom_range(6))
		0: return -32768;
		1: return -32767;
		2: return -1;
		3: return 0;
		4: return 1;
		5: return 32766;
		default: return 32767;
		endcase
	endfunction

	task automatic pick_pair(input pair_kind_t kind, output int o, output int m);
		int span;
		case (kind)
		K_NOISY: begin
			span = 1 << $urandom_range(12);
			o = $signed(16'($urandom));
			m = o + int'($urandom_range(2 * span)) - span;
		end
		K_EXACT: begin
			o = $signed(16'($urandom));
			m = o;
		end
		K_MUTE: begin
			o = 0;
			m = $signed(16'($urandom));
		end
		K_QUIET: begin
			o = int'($urandom_range(32)) - 16;
			m = $signed(16'($urandom));
		end
		K_EXTREME: begin
			o = pick_extreme();
			m = pick_extreme();
		end
		default: begin
			o = $signed(16'($urandom));
			m = $signed(16'($urandom));
		end
		endcase
	endtask

	// One measurement of the given length; a mixed one draws a new kind for every pair.
	task automatic send_measurement(input int unsigned len);
		int         r;
		int         o;
		int         m;
		bit         mixed;
		pair_kind_t kind;
		mixed = 1'b0;
		r = $urandom_range(9);
		case (r)
		0, 1, 2: kind = K_RANDOM;
		3, 4: kind = K_NOISY;
		5: kind = K_EXACT;
		6: kind = K_MUTE;
		7: kind = K_QUIET;
		8: kind = K_EXTREME;
		default: begin
			kind = K_RANDOM;
			mixed = 1'b1;
		end
		endcase
		for (int unsigned k = 0; k < len; k++) begin
			if (mixed)
				kind = pair_kind_t'($urandom_range(5));
			pick_pair(kind, o, m);
			send_pair(o, m, k == len - 1);
		end
	endtask

	function automatic int unsigned random_length();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return $urandom_range(4, 1);
		else if (r < 80)
			return $urandom_range(32, 5);
		else if (r < 95)
			return $urandom_range(128, 33);
		return $urandom_range(400, 129);
	endfunction

	task automatic run_directed();
		send_pair(0, 0, 1);
		send_pair(0, -32768, 1);
		send_pair(1234, 1234, 1);
		send_pair(-32768, -32768, 1);
		send_pair(32767, -32768, 1);
		send_pair(-32768, 32767, 1);
		send_pair(-32768, -32767, 1);
		send_pair(1, 0, 1);
		send_pair(1, 3, 1);
		send_pair(2, 1, 1);
		send_pair(100, 90, 0);
		send_pair(-200, -180, 0);
		send_pair(32767, 32760, 1);
		// The peak comes early and must survive smaller errors after it.
		send_pair(5000, -5000, 0);
		send_pair(7, 7, 0);
		send_pair(-1, 0, 1);
		send_pair(0, 0, 0);
		send_pair(0, 0, 0);
		send_pair(0, 1, 1);
		send_pair(0, 0, 0);
		send_pair(-3, -3, 1);
		send_pair(32767, 0, 0);
		send_pair(32767, 0, 0);
		send_pair(32767, 0, 0);
		send_pair(-32768, 0, 1);
	endtask

	initial begin
		bit pressure_done;
		pressure_done = 1'b0;
		sb = new();
		in_ch.valid = 1'b0;
		in_ch.original_sample = '0;
		in_ch.modified_sample = '0;
		in_ch.last_pair = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		run_directed();
		drain_results();
		while (sent_pairs < ITEMS) begin
			idle_on = !(sent_pairs >= 900 && sent_pairs < 1300);
			if (!pressure_done && sent_pairs >= 600) begin
				// Short measurements back to back against a stalled output fill the block.
				pressure_done = 1'b1;
				hold_req = 300;
				repeat (12) send_measurement($urandom_range(3, 1));
				drain_results();
			end else begin
				send_measurement(random_length());
				if ($urandom_range(9) == 0)
					drain_results();
			end
		end
		idle_on = 1'b1;
		drain_results();
		repeat (LATENCY + 10) @(posedge clk);
		$display("Covered %0d sample pairs in %0d measurements, %0d result words checked.",
			sent_pairs, sb.measurements, sb.checked);
		$display("Status mix: valid %0d, zero error %0d, zero signal %0d; negative SNR %0d.",
			sb.status_count[0], sb.status_count[1], sb.status_count[2], sb.negative_snr);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("** snr_and_peak_error_meter: PASSED **");
		end else begin
			$display("** snr_and_peak_error_meter: FAILED **");
		end
		$finish;
	end

	initial begin
		int unsigned hold_left;
		hold_left = 0;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
				sb.check_result(out_ch.snr_db_q8, out_ch.max_abs_error, out_ch.snr_status);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left != 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= !(idle_on && $urandom_range(99) < 21);
			end
		end
	end
endmodule
